FILE: sv/rast_pkg.sv
// Package: shared constants, types and helpers for the range assign / range sum tree.
`timescale 1ns / 1ps
package rast_pkg;
  localparam int unsigned MaxPositions = 1024;
  localparam int unsigned NodeCount    = 4 * MaxPositions;
  localparam int unsigned NodeW        = $clog2(NodeCount);
  localparam int unsigned PosW         = $clog2(MaxPositions) + 1;
  localparam int unsigned ValW         = 32;
  localparam int unsigned SumW         = 48;
  // each split node on the path leaves its right child and, for an assign, its own post visit
  localparam int unsigned StackDepth   = 2 * ($clog2(MaxPositions) + 1);
  localparam int unsigned StackW       = $clog2(StackDepth + 1);

  typedef enum logic {
    OP_ASSIGN = 1'b0,
    OP_SUM    = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    REG_ACTIVE_LENGTH = 1'b0
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_POP, S_READ, S_VISIT, S_KID_L, S_KID_R, S_SPLIT,
    S_POST_A, S_POST_B, S_DONE
  } eng_state_e;

  typedef struct packed {
    logic [NodeW-1:0] nd;
    logic [PosW-1:0]  lo;
    logic [PosW-1:0]  hi;
    logic             post;
  } frame_t;

  typedef struct packed {
    logic            pv;
    logic [ValW-1:0] pval;
  } pend_t;

  typedef struct packed {
    logic             op;
    logic [PosW-1:0]  range_low;
    logic [PosW-1:0]  range_high;
    logic [ValW-1:0]  fill_value;
  } req_t;

  typedef struct packed {
    logic [SumW-1:0] range_sum;
  } rsp_t;

  typedef struct packed {
    logic             re;
    logic [NodeW-1:0] raddr;
    logic             we;
    logic [NodeW-1:0] waddr;
  } mem_ctl_t;
endpackage

FILE: sv/rast_if.sv
// Interface: valid/ready channel with a generic payload.
`timescale 1ns / 1ps
interface rast_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/rast_node_ram.sv
// Node store: generic synchronous RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps
module rast_node_ram
  import rast_pkg::*;
#(
  parameter int unsigned Width = 1
) (
  input  logic             clk_i,
  input  mem_ctl_t         ctl_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [NodeCount];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) mem[ctl_i.waddr] <= wdata_i;
    if (ctl_i.re) rdata_o <= mem[ctl_i.raddr];
  end
endmodule

FILE: sv/rast_engine.sv
// Tree walker: explicit stack, read-modify-write of one node per visit.
`timescale 1ns / 1ps
module rast_engine
  import rast_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  logic [PosW-1:0] len_i,
  rast_if.sink            req_if,
  rast_if.source          rsp_if,
  output mem_ctl_t        sum_ctl_o,
  output logic [SumW-1:0] sum_wdata_o,
  input  logic [SumW-1:0] sum_rdata_i,
  output mem_ctl_t        pend_ctl_o,
  output pend_t           pend_wdata_o,
  input  pend_t           pend_rdata_i,
  output logic            busy_o
);
  localparam int unsigned ProdW = PosW + 1 + ValW;

  eng_state_e st_q, st_d;
  frame_t stk_q [StackDepth];
  logic [StackW-1:0] sp_q, sp_d;
  frame_t cur_q, cur_d;
  req_t req_q;
  logic [SumW-1:0] acc_q, acc_d;
  logic [SumW-1:0] lsum_q, lsum_d;
  logic [ValW-1:0] kid_val_q, kid_val_d;
  logic split_q, split_d;
  logic [NodeW-1:0] clr_q, clr_d;
  logic out_v_q;
  logic [SumW-1:0] out_q;
  logic push0, push1;
  frame_t push0_f, push1_f;
  logic [NodeW-1:0] kid_l, kid_r;
  logic [PosW-1:0] mid;
  logic [PosW-1:0] cnt;
  logic leaf, outside, covered, asg_hit, kid_push;
  logic [ValW-1:0] mul_val;
  logic signed [ProdW-1:0] prod;
  logic [SumW-1:0] settled;

  assign mid     = PosW'((({1'b0, cur_q.lo} + {1'b0, cur_q.hi}) >> 1));
  assign cnt     = cur_q.hi - cur_q.lo + PosW'(1);
  assign leaf    = cur_q.lo == cur_q.hi;
  assign kid_l   = {cur_q.nd[NodeW-2:0], 1'b0};
  assign kid_r   = {cur_q.nd[NodeW-2:0], 1'b1};
  assign outside = (cur_q.hi < req_q.range_low) || (req_q.range_high < cur_q.lo);
  assign covered = (cur_q.lo >= req_q.range_low) && (cur_q.hi <= req_q.range_high);
  assign busy_o  = st_q != S_IDLE;
  assign req_if.ready = st_q == S_IDLE && !out_v_q;
  assign rsp_if.valid = out_v_q;
  assign rsp_if.payload.range_sum = out_q;

  // settle: a covered assign takes the new value, else a pending fill is applied, else the stored sum stays
  assign asg_hit  = !outside && covered && req_q.op == OP_ASSIGN;
  assign mul_val  = asg_hit ? req_q.fill_value : pend_rdata_i.pval;
  assign prod     = $signed({1'b0, cnt}) * $signed(mul_val);
  assign settled  = (asg_hit || pend_rdata_i.pv) ? SumW'(prod) : sum_rdata_i;
  assign kid_push = !leaf && (asg_hit || pend_rdata_i.pv);

  always_comb begin
    st_d = st_q; sp_d = sp_q; cur_d = cur_q; acc_d = acc_q; lsum_d = lsum_q;
    kid_val_d = kid_val_q; split_d = split_q; clr_d = clr_q;
    sum_ctl_o = '0; sum_wdata_o = '0; pend_ctl_o = '0; pend_wdata_o = '0;
    push0 = 1'b0; push1 = 1'b0; push0_f = '0; push1_f = '0;
    case (st_q)
      S_CLEAR: begin
        sum_ctl_o.we = 1'b1; sum_ctl_o.waddr = clr_q;
        pend_ctl_o.we = 1'b1; pend_ctl_o.waddr = clr_q;
        clr_d = clr_q + NodeW'(1);
        if (clr_q == NodeW'(NodeCount - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_if.valid && req_if.ready) begin
          acc_d = '0;
          if (req_if.payload.range_low <= req_if.payload.range_high) begin
            cur_d = '{nd: NodeW'(1), lo: PosW'(1), hi: len_i, post: 1'b0};
            sp_d = '0;
            st_d = S_READ;
          end else st_d = S_DONE;
        end
      end
      S_POP: begin
        if (sp_q == '0) st_d = S_DONE;
        else begin
          cur_d = stk_q[sp_q - StackW'(1)];
          sp_d = sp_q - StackW'(1);
          st_d = S_READ;
        end
      end
      S_READ: begin
        sum_ctl_o.re = 1'b1;
        if (cur_q.post) begin
          sum_ctl_o.raddr = kid_l;
          st_d = S_POST_A;
        end else begin
          sum_ctl_o.raddr = cur_q.nd;
          pend_ctl_o.re = 1'b1; pend_ctl_o.raddr = cur_q.nd;
          st_d = S_VISIT;
        end
      end
      S_VISIT: begin
        sum_ctl_o.we = 1'b1; sum_ctl_o.waddr = cur_q.nd; sum_wdata_o = settled;
        pend_ctl_o.we = 1'b1; pend_ctl_o.waddr = cur_q.nd;
        kid_val_d = mul_val;
        split_d = !outside && !covered;
        if (!outside && covered && req_q.op == OP_SUM) acc_d = acc_q + settled;
        if (kid_push) st_d = S_KID_L;
        else if (!outside && !covered) st_d = S_SPLIT;
        else st_d = S_POP;
      end
      S_KID_L: begin
        pend_ctl_o.we = 1'b1; pend_ctl_o.waddr = kid_l;
        pend_wdata_o = '{pv: 1'b1, pval: kid_val_q};
        st_d = S_KID_R;
      end
      S_KID_R: begin
        pend_ctl_o.we = 1'b1; pend_ctl_o.waddr = kid_r;
        pend_wdata_o = '{pv: 1'b1, pval: kid_val_q};
        st_d = split_q ? S_SPLIT : S_POP;
      end
      S_SPLIT: begin
        // left child goes straight on; right child (and, for an assign, parent update) wait on the stack
        push0 = 1'b1;
        if (req_q.op == OP_ASSIGN) begin
          push0_f = '{nd: cur_q.nd, lo: cur_q.lo, hi: cur_q.hi, post: 1'b1};
          push1 = 1'b1;
          push1_f = '{nd: kid_r, lo: mid + PosW'(1), hi: cur_q.hi, post: 1'b0};
          sp_d = sp_q + StackW'(2);
        end else begin
          push0_f = '{nd: kid_r, lo: mid + PosW'(1), hi: cur_q.hi, post: 1'b0};
          sp_d = sp_q + StackW'(1);
        end
        cur_d = '{nd: kid_l, lo: cur_q.lo, hi: mid, post: 1'b0};
        st_d = S_READ;
      end
      S_POST_A: begin
        sum_ctl_o.re = 1'b1; sum_ctl_o.raddr = kid_r;
        lsum_d = sum_rdata_i;
        st_d = S_POST_B;
      end
      S_POST_B: begin
        sum_ctl_o.we = 1'b1; sum_ctl_o.waddr = cur_q.nd;
        sum_wdata_o = lsum_q + sum_rdata_i;
        st_d = S_POP;
      end
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
    if (clear_i) begin
      st_d = S_CLEAR;
      clr_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_if.valid && req_if.ready) req_q <= req_if.payload;
    cur_q <= cur_d; acc_q <= acc_d; lsum_q <= lsum_d;
    kid_val_q <= kid_val_d; split_q <= split_d;
    if (push0) stk_q[sp_q] <= push0_f;
    if (push1) stk_q[sp_q + StackW'(1)] <= push1_f;
    if (st_q == S_DONE) out_q <= acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR; sp_q <= '0; clr_q <= '0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; sp_q <= sp_d; clr_q <= clr_d;
      if (st_q == S_DONE && req_q.op == OP_SUM) out_v_q <= 1'b1;
      else if (rsp_if.ready) out_v_q <= 1'b0;
    end
  end
endmodule

FILE: sv/range_assign_range_sum_tree_unit.sv
// Top level: range assign / range sum lazy segment tree.
// channel | dir | payload
// req_if  | in  | op, range_low, range_high, fill_value
// rsp_if  | out | range_sum (sum requests only)
// apb     | in  | active_length at address 0
// A node visit reads the node, settles it and, if it takes or holds a fill and is not a
// leaf, writes pending fills to both children; a walk touches up to about 40 nodes plus parent updates.
// An empty range goes from idle straight to the done state, without a walk.
// After reset and after every length write both node RAMs are cleared one entry
// a cycle, all 4096 entries, with ready low.
// One request at a time; a result waiting for the sink blocks the next request.
`timescale 1ns / 1ps
module range_assign_range_sum_tree_unit
  import rast_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rast_if.sink        req_if,
  rast_if.source      rsp_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [PosW-1:0] len_q;
  logic [PosW-1:0] len_eff;
  logic            cfg_wr;
  mem_ctl_t        sum_ctl;
  mem_ctl_t        pend_ctl;
  logic [SumW-1:0] sum_wdata;
  logic [SumW-1:0] sum_rdata;
  pend_t           pend_wdata;
  pend_t           pend_rdata;
  logic            busy;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && paddr == 1'(REG_ACTIVE_LENGTH);
  assign prdata = 32'(len_q);
  assign len_eff = len_q == '0 ? PosW'(1) :
                   (len_q > PosW'(MaxPositions) ? PosW'(MaxPositions) : len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) len_q <= PosW'(1024);
    else if (cfg_wr) len_q <= pwdata[PosW-1:0];
  end

  rast_node_ram #(.Width(SumW)) u_sum_ram (
    .clk_i, .ctl_i(sum_ctl), .wdata_i(sum_wdata), .rdata_o(sum_rdata)
  );

  rast_node_ram #(.Width($bits(pend_t))) u_pend_ram (
    .clk_i, .ctl_i(pend_ctl), .wdata_i(pend_wdata), .rdata_o(pend_rdata)
  );

  rast_engine u_eng (
    .clk_i, .rst_ni, .clear_i(cfg_wr), .len_i(len_eff), .req_if, .rsp_if,
    .sum_ctl_o(sum_ctl), .sum_wdata_o(sum_wdata), .sum_rdata_i(sum_rdata),
    .pend_ctl_o(pend_ctl), .pend_wdata_o(pend_wdata), .pend_rdata_i(pend_rdata),
    .busy_o(busy)
  );

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_if.ready |-> !busy) else $error("ready while busy");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_ctl.we || pend_ctl.we) |-> busy) else $error("ram write while idle");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.payload.range_sum))
    else $error("result dropped or changed while stalled");
endmodule
